FILE: design/pf_pkg.sv
// Package for the Playfair encryptor: square geometry, letter codes,
// input kinds, sequencer states, port structs and small helper functions.
// No dependencies.
package pf_pkg;

    localparam int GRID_SIDE   = 5;
    localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int NUM_LETTERS = 26;

    localparam logic [4:0] LET_I = 5'd8;
    localparam logic [4:0] LET_J = 5'd9;
    localparam logic [4:0] LET_X = 5'd23;
    localparam logic [4:0] LET_Y = 5'd24;
    localparam logic [4:0] LET_LAST = 5'(NUM_LETTERS - 1);
    localparam logic [4:0] CELLS_FULL = 5'(GRID_CELLS);

    localparam logic [6:0] ASCII_A = 7'h41;
    localparam logic [7:0] BYTE_UC_A = 8'h41;
    localparam logic [7:0] BYTE_UC_Z = 8'h5A;
    localparam logic [7:0] BYTE_LC_A = 8'h61;
    localparam logic [7:0] BYTE_LC_Z = 8'h7A;

    typedef enum logic [2:0] {
        KIND_KEY_START = 3'd0,
        KIND_KEY_CHAR  = 3'd1,
        KIND_KEY_END   = 3'd2,
        KIND_MSG_CHAR  = 3'd3,
        KIND_MSG_END   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CI_IDLE,
        CI_RD_A,
        CI_RD_B,
        CI_CALC,
        CI_RD_Q2,
        CI_CAP,
        CI_EMIT
    } ci_state_t;

    // one key placement: letter_place[letter] <= place, place_letter[place] <= letter
    typedef struct packed {
        logic       en;
        logic [4:0] letter;
        logic [4:0] place;
    } pf_wr_t;

    typedef struct packed {
        logic       en;
        logic [4:0] addr;
    } pf_rd_t;

    // folded letter index; valid low for a non-letter byte
    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } pf_letter_t;

    function automatic pf_letter_t fold_letter(input logic [7:0] code);
        pf_letter_t res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        if (code >= BYTE_LC_A && code <= BYTE_LC_Z)
        begin
            diff      = code - BYTE_LC_A;
            res.valid = 1'b1;
        end
        else if (code >= BYTE_UC_A && code <= BYTE_UC_Z)
        begin
            diff      = code - BYTE_UC_A;
            res.valid = 1'b1;
        end
        res.idx = diff[4:0];
        if (res.idx == LET_J)
            res.idx = LET_I;
        return res;
    endfunction

    // row of a square position, by compares against the row starts
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        r = '0;
        for (int k = 1; k < GRID_SIDE; k++)
            if (p >= 5'(k * GRID_SIDE))
                r = 3'(k);
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [4:0] base;
        base = 5'(pos_row(p) * GRID_SIDE);
        return 3'(p - base);
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(GRID_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] make_pos(input logic [2:0] r, input logic [2:0] c);
        return 5'(r * GRID_SIDE) + {2'b00, c};
    endfunction

endpackage

FILE: design/pf_req_if.sv
// Input channel of the Playfair encryptor: valid/ready plus kind and byte.
// No dependencies.
interface pf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

FILE: design/pf_rsp_if.sv
// Result channel of the Playfair encryptor: valid/ready plus cipher pair.
// No dependencies.
interface pf_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] first_letter;
    logic [6:0] second_letter;
    logic       pair_valid;
    logic       end_of_message;

    modport source (output valid, output first_letter, output second_letter,
                    output pair_valid, output end_of_message, input ready);
    modport sink   (input valid, input first_letter, input second_letter,
                    input pair_valid, input end_of_message, output ready);
endinterface

FILE: design/pf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pf_key_builder.sv
// Key square builder: used-letter set, fill count and the completion sweep.
// Drives the write ports of both square memories. Depends on pf_pkg.
module pf_key_builder
    import pf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [2:0] kind,
    input  logic [7:0] char_code,
    output logic       busy,
    output pf_wr_t     wr
);

    logic [NUM_LETTERS-1:0] used_reg, used_next;
    logic [4:0]             fill_reg, fill_next;
    logic                   sweep_reg, sweep_next;
    logic [4:0]             sweep_idx_reg, sweep_idx_next;

    pf_letter_t key_let;
    pf_letter_t cand;
    logic       do_place;

    always_comb
    begin
        key_let = fold_letter(char_code);
        cand    = '0;
        if (sweep_reg)
        begin
            cand.valid = (sweep_idx_reg != LET_J);
            cand.idx   = sweep_idx_reg;
        end
        else if (accept && kind == KIND_KEY_CHAR)
        begin
            cand = key_let;
        end
        do_place = cand.valid && (fill_reg < CELLS_FULL) && !used_reg[cand.idx];

        used_next      = used_reg;
        fill_next      = fill_reg;
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;

        if (do_place)
        begin
            used_next[cand.idx] = 1'b1;
            fill_next           = fill_reg + 5'd1;
        end

        if (sweep_reg)
        begin
            sweep_idx_next = sweep_idx_reg + 5'd1;
            if (sweep_idx_reg == LET_LAST)
                sweep_next = 1'b0;
        end
        else if (accept)
        begin
            unique case (kind)
                KIND_KEY_START:
                begin
                    used_next = '0;
                    fill_next = '0;
                end
                KIND_KEY_END:
                begin
                    sweep_next     = 1'b1;
                    sweep_idx_next = '0;
                end
                default: ;
            endcase
        end

        wr.en     = do_place;
        wr.letter = cand.idx;
        wr.place  = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fill_reg      <= '0;
            sweep_reg     <= 1'b0;
            sweep_idx_reg <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
        end
    end

    assign busy = sweep_reg;

endmodule

FILE: design/pf_cipher.sv
// Message pairing and pair encryption: reads letter_place then place_letter,
// applies the row, column and rectangle rules, holds the result word.
// Depends on pf_pkg and pf_rsp_if.
module pf_cipher
    import pf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [2:0] kind,
    input  logic [7:0] char_code,
    output logic       busy,
    output pf_rd_t     lp_rd,
    input  logic [4:0] lp_data,
    output pf_rd_t     pl_rd,
    input  logic [4:0] pl_data,
    pf_rsp_if.source   rsp
);

    ci_state_t  state_reg, state_next;
    logic [4:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;
    logic [4:0] a_reg, a_next;
    logic [4:0] b_reg, b_next;
    logic [4:0] p1_reg, p1_next;
    logic [4:0] q2_reg, q2_next;
    logic [6:0] st_first_reg, st_first_next;
    logic [6:0] st_second_reg, st_second_next;
    logic       st_pv_reg, st_pv_next;
    logic       st_eom_reg, st_eom_next;

    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_first_reg, out_second_reg;
    logic       out_pv_reg, out_eom_reg;
    logic       out_load;

    pf_letter_t msg_let;
    logic       start_pair;
    logic [4:0] pa, pb;
    logic [4:0] p1c, p2c;
    logic [2:0] r1, c1, r2, c2;
    logic [4:0] q1;

    always_comb
    begin
        msg_let = fold_letter(char_code);

        // out-of-square positions read as position zero
        p1c = (p1_reg < CELLS_FULL) ? p1_reg : 5'd0;
        p2c = (lp_data < CELLS_FULL) ? lp_data : 5'd0;
        r1 = pos_row(p1c);
        c1 = pos_col(p1c);
        r2 = pos_row(p2c);
        c2 = pos_col(p2c);
        if (r1 == r2)
        begin
            c1 = wrap_inc(c1);
            c2 = wrap_inc(c2);
        end
        else if (c1 == c2)
        begin
            r1 = wrap_inc(r1);
            r2 = wrap_inc(r2);
        end
        else
        begin
            c1 = pos_col(p2c);
            c2 = pos_col(p1c);
        end
        q1 = make_pos(r1, c1);

        state_next      = state_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        p1_next         = p1_reg;
        q2_next         = q2_reg;
        st_first_next   = st_first_reg;
        st_second_next  = st_second_reg;
        st_pv_next      = st_pv_reg;
        st_eom_next     = st_eom_reg;
        lp_rd           = '0;
        pl_rd           = '0;
        out_load        = 1'b0;
        start_pair      = 1'b0;
        pa              = held_reg;
        pb              = LET_X;

        unique case (state_reg)
            CI_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_KEY_START: held_valid_next = 1'b0;
                        KIND_MSG_CHAR:
                        begin
                            if (msg_let.valid)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_next       = msg_let.idx;
                                    held_valid_next = 1'b1;
                                end
                                else
                                begin
                                    // doubled letter pairs with X and stays pending
                                    if (held_reg != msg_let.idx)
                                    begin
                                        pb              = msg_let.idx;
                                        held_valid_next = 1'b0;
                                    end
                                    start_pair  = 1'b1;
                                    st_eom_next = 1'b0;
                                end
                            end
                        end
                        KIND_MSG_END:
                        begin
                            st_eom_next = 1'b1;
                            if (held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                start_pair      = 1'b1;
                            end
                            else
                            begin
                                st_first_next  = '0;
                                st_second_next = '0;
                                st_pv_next     = 1'b0;
                                state_next     = CI_EMIT;
                            end
                        end
                        default: ;
                    endcase

                    if (start_pair)
                    begin
                        a_next     = pa;
                        b_next     = pb;
                        st_pv_next = 1'b1;
                        if (pa == LET_X && pb == LET_X)
                        begin
                            st_first_next  = ASCII_A + {2'b00, LET_Y};
                            st_second_next = ASCII_A + {2'b00, LET_Y};
                            state_next     = CI_EMIT;
                        end
                        else
                        begin
                            state_next = CI_RD_A;
                        end
                    end
                end
            end
            CI_RD_A:
            begin
                lp_rd.en   = 1'b1;
                lp_rd.addr = a_reg;
                state_next = CI_RD_B;
            end
            CI_RD_B:
            begin
                lp_rd.en   = 1'b1;
                lp_rd.addr = b_reg;
                p1_next    = lp_data;
                state_next = CI_CALC;
            end
            CI_CALC:
            begin
                pl_rd.en   = 1'b1;
                pl_rd.addr = q1;
                q2_next    = make_pos(r2, c2);
                state_next = CI_RD_Q2;
            end
            CI_RD_Q2:
            begin
                pl_rd.en      = 1'b1;
                pl_rd.addr    = q2_reg;
                st_first_next = ASCII_A + {2'b00, pl_data};
                state_next    = CI_CAP;
            end
            CI_CAP:
            begin
                st_second_next = ASCII_A + {2'b00, pl_data};
                state_next     = CI_EMIT;
            end
            CI_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = CI_IDLE;
                end
            end
            default: state_next = CI_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CI_IDLE;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        p1_reg        <= p1_next;
        q2_reg        <= q2_next;
        st_first_reg  <= st_first_next;
        st_second_reg <= st_second_next;
        st_pv_reg     <= st_pv_next;
        st_eom_reg    <= st_eom_next;
        if (out_load)
        begin
            out_first_reg  <= st_first_reg;
            out_second_reg <= st_second_reg;
            out_pv_reg     <= st_pv_reg;
            out_eom_reg    <= st_eom_reg;
        end
    end

    assign busy              = (state_reg != CI_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.first_letter  = out_first_reg;
    assign rsp.second_letter = out_second_reg;
    assign rsp.pair_valid    = out_pv_reg;
    assign rsp.end_of_message = out_eom_reg;

`ifndef SYNTHESIS
    // a word only appears after the emit state
    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == CI_EMIT)
        else $error("result word loaded outside emit");

    // a word without a pair is the bare end-of-message marker
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pv_reg) |->
            (out_eom_reg && out_first_reg == 7'd0 && out_second_reg == 7'd0))
        else $error("empty word carries letters");

    // the two letter_place reads are back to back and feed the square read
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CI_RD_A) |=> (state_reg == CI_RD_B) ##1 (state_reg == CI_CALC))
        else $error("lookup sequence broken");

    // message end never leaves a letter pending
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg == CI_IDLE && kind == KIND_MSG_END) |=> !held_valid_reg)
        else $error("pending letter survives message end");
`endif

endmodule

FILE: design/playfair_encryptor_core.sv
// Top level of the Playfair encryptor: dispatches input words to the key
// builder and the cipher sequencer, holds the two square memories.
// Depends on pf_pkg, pf_req_if, pf_rsp_if, pf_ram, pf_key_builder, pf_cipher.
//
//   channel  dir  fields                                              
//   req      in   kind[2:0], char_code[7:0]                           
//   rsp      out  first_letter[6:0], second_letter[6:0], pair_valid,  
//                 end_of_message                                      
//
// Key end starts a completion sweep over all 26 letters, one letter per cycle.
// A message pair steps through the states RD_A, RD_B, CALC, RD_Q2, CAP and EMIT
// for two letter_place and two place_letter reads through the single read port
// of each memory; an XX pair and a bare message end go straight to EMIT.
// Reset clears the used-letter set, fill count and pending letter; the
// memories are not cleared. The result register lets the next word in while
// a result waits; a stalled rsp only holds the sequencer in its emit state.
module playfair_encryptor_core
    import pf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pf_req_if.sink   req,
    pf_rsp_if.source rsp
);

    logic       accept;
    logic       kb_busy;
    logic       ci_busy;
    pf_wr_t     kb_wr;
    pf_rd_t     lp_rd;
    pf_rd_t     pl_rd;
    logic [4:0] lp_data;
    logic [4:0] pl_data;

    assign req.ready = !kb_busy && !ci_busy;
    assign accept    = req.valid && req.ready;

    pf_key_builder u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (req.kind),
        .char_code (req.char_code),
        .busy      (kb_busy),
        .wr        (kb_wr)
    );

    pf_cipher u_cipher (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (req.kind),
        .char_code (req.char_code),
        .busy      (ci_busy),
        .lp_rd     (lp_rd),
        .lp_data   (lp_data),
        .pl_rd     (pl_rd),
        .pl_data   (pl_data),
        .rsp       (rsp)
    );

    // letter -> square position
    pf_ram #(.WIDTH(5), .DEPTH(NUM_LETTERS)) u_letter_place (
        .clk     (clk),
        .wr_en   (kb_wr.en),
        .wr_addr (kb_wr.letter),
        .wr_data (kb_wr.place),
        .rd_en   (lp_rd.en),
        .rd_addr (lp_rd.addr),
        .rd_data (lp_data)
    );

    // square position -> letter
    pf_ram #(.WIDTH(5), .DEPTH(GRID_CELLS)) u_place_letter (
        .clk     (clk),
        .wr_en   (kb_wr.en),
        .wr_addr (kb_wr.place),
        .wr_data (kb_wr.letter),
        .rd_en   (pl_rd.en),
        .rd_addr (pl_rd.addr),
        .rd_data (pl_data)
    );

endmodule
